### design/fmpe_pkg.sv
// Shared types, constants and saturation helpers for the FM pre-emphasis unit.
package fmpe_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int Y_W       = SAMPLE_W + 8;
  localparam int COEF_FRAC = COEF_W - 2;
  localparam int ACC_W     = COEF_W + Y_W + 3;
  localparam int OUT_SHIFT = 3;

  localparam int NUM_REGS  = 6;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam logic [IDX_W-1:0] REG_FWD_50 = 3'd0;
  localparam logic [IDX_W-1:0] REG_FB0_50 = 3'd1;
  localparam logic [IDX_W-1:0] REG_FB1_50 = 3'd2;
  localparam logic [IDX_W-1:0] REG_FWD_75 = 3'd3;
  localparam logic [IDX_W-1:0] REG_FB0_75 = 3'd4;
  localparam logic [IDX_W-1:0] REG_FB1_75 = 3'd5;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_50     = 2'd1;
  localparam logic [1:0] MODE_75     = 2'd2;
  localparam logic [1:0] MODE_50_ALT = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [Y_W-1:0]      yval_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    coef_t fwd;
    coef_t fb0;
    coef_t fb1;
  } tap_set_t;

  // Clamp a wide accumulator value to the internal y range.
  function automatic yval_t sat_y(input acc_t v);
    logic fits;
    begin
      fits = (v[ACC_W-1:Y_W-1] == {(ACC_W-Y_W+1){1'b0}}) ||
             (v[ACC_W-1:Y_W-1] == {(ACC_W-Y_W+1){1'b1}});
      if (fits) begin
        sat_y = v[Y_W-1:0];
      end else if (v[ACC_W-1]) begin
        sat_y = {1'b1, {(Y_W-1){1'b0}}};
      end else begin
        sat_y = {1'b0, {(Y_W-1){1'b1}}};
      end
    end
  endfunction

  // Clamp a wide accumulator value to the sample range.
  function automatic sample_t sat_sample(input acc_t v);
    logic fits;
    begin
      fits = (v[ACC_W-1:SAMPLE_W-1] == {(ACC_W-SAMPLE_W+1){1'b0}}) ||
             (v[ACC_W-1:SAMPLE_W-1] == {(ACC_W-SAMPLE_W+1){1'b1}});
      if (fits) begin
        sat_sample = v[SAMPLE_W-1:0];
      end else if (v[ACC_W-1]) begin
        sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

### design/fmpe_regs.sv
// APB-style register file holding the filter taps of both emphasis modes.
module fmpe_regs
  import fmpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output tap_set_t          taps_50,
  output tap_set_t          taps_75
);

  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;
  coef_t            wr_val;
  coef_t            rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_val  = pwdata[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_50 <= '0;
      taps_75 <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FWD_50: taps_50.fwd <= wr_val;
        REG_FB0_50: taps_50.fb0 <= wr_val;
        REG_FB1_50: taps_50.fb1 <= wr_val;
        REG_FWD_75: taps_75.fwd <= wr_val;
        REG_FB0_75: taps_75.fb0 <= wr_val;
        REG_FB1_75: taps_75.fb1 <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FWD_50: rd_val = taps_50.fwd;
      REG_FB0_50: rd_val = taps_50.fb0;
      REG_FB1_50: rd_val = taps_50.fb1;
      REG_FWD_75: rd_val = taps_75.fwd;
      REG_FB0_75: rd_val = taps_75.fb0;
      REG_FB1_75: rd_val = taps_75.fb1;
      default:    rd_val = '0;
    endcase
  end

  // Taps read back sign-extended to the bus width.
  assign prdata = DATA_W'(rd_val);

endmodule

### design/fmpe_datapath.sv
// Filter arithmetic and history registers of the pre-emphasis IIR.
module fmpe_datapath
  import fmpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  sample_t  x,
  input  logic [1:0] mode,
  input  tap_set_t taps_50,
  input  tap_set_t taps_75,
  output sample_t  result
);

  logic [1:0] prev_mode;
  sample_t    prev_in;
  yval_t      y1;
  yval_t      y2;

  logic [1:0] mode_eff;
  logic       mode_change;
  tap_set_t   t;

  logic signed [COEF_W+SAMPLE_W-1:0] p_fwd;
  logic signed [COEF_W+Y_W-1:0]      p_fb0;
  logic signed [COEF_W+Y_W-1:0]      p_fb1;
  acc_t  acc;
  acc_t  acc_shr;
  yval_t y_new;
  acc_t  y_gain;

  assign mode_eff    = (mode == MODE_50_ALT) ? MODE_50 : mode;
  assign mode_change = (mode_eff != prev_mode);
  assign t           = (mode_eff == MODE_75) ? taps_75 : taps_50;

  // Three products in parallel, summed exactly, then rounded half up.
  assign p_fwd = t.fwd * prev_in;
  assign p_fb0 = t.fb0 * y1;
  assign p_fb1 = t.fb1 * y2;

  assign acc = (ACC_W'(x) <<< COEF_FRAC) + ACC_W'(p_fwd) + ACC_W'(p_fb0)
             + ACC_W'(p_fb1) + (acc_t'(1) <<< (COEF_FRAC - 1));
  assign acc_shr = acc >>> COEF_FRAC;
  assign y_new   = sat_y(acc_shr);
  assign y_gain  = ACC_W'(y_new) <<< OUT_SHIFT;

  always_comb begin
    if (mode_eff == MODE_NONE || mode_change) begin
      result = x;
    end else begin
      result = sat_sample(y_gain);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mode <= MODE_NONE;
      prev_in   <= '0;
      y1        <= '0;
      y2        <= '0;
    end else if (advance && mode_eff != MODE_NONE) begin
      prev_in <= x;
      if (mode_change) begin
        prev_mode <= mode_eff;
        y1        <= Y_W'(x);
      end else begin
        y2 <= y1;
        y1 <= y_new;
      end
    end
  end

endmodule

### design/fm_preemphasis_iir_unit.sv
// Top level of the FM pre-emphasis IIR: request and result stages, taps, filter.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  request   | req_valid / req_stall     | sample_in, emphasis_mode
//  result    | res_valid / res_stall     | sample_out
//  config    | psel penable pwrite pready| paddr, pwdata, prdata
//
// One request is taken every cycle while the result side is not stalled; its
// result passes through the input register, then the result register, and is
// presented from the result register. The rate is set by the history feedback,
// which closes combinationally through the three tap multipliers and the
// accumulate/saturate path.
// Reset is synchronous and active high; it clears both stage valids, the
// filter history and all taps to zero.
// While the result register is held by res_stall, a request in the input register
// stays there and req_stall rises; neither side loses or repeats an item.
module fm_preemphasis_iir_unit
  import fmpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sample_t           sample_in,
  input  logic [1:0]        emphasis_mode,
  output logic              res_valid,
  input  logic              res_stall,
  output sample_t           sample_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  tap_set_t   taps_50;
  tap_set_t   taps_75;

  // Input register holding the request under work.
  logic       s1_valid;
  sample_t    s1_x;
  logic [1:0] s1_mode;

  logic       advance;
  logic       req_take;
  sample_t    result;

  fmpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .taps_50 (taps_50),
    .taps_75 (taps_75)
  );

  // The request moves into the result register when that register is free
  // or is emptied this cycle; history updates on that edge unless in MODE_NONE.
  assign advance   = s1_valid && (!res_valid || !res_stall);
  assign req_stall = s1_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  fmpe_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .x       (s1_x),
    .mode    (s1_mode),
    .taps_50 (taps_50),
    .taps_75 (taps_75),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_x    <= sample_in;
      s1_mode <= emphasis_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= result;
    end
  end

  // A held request must stay in the input register until it can move on.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_x) && $stable(s1_mode))
    else $error("held request lost from input register");

  // The input side is only stalled when a request is waiting to move on.
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && res_valid && res_stall)
    else $error("request stalled without a blocked result");

  // A MODE_NONE request delivers its own sample unchanged.
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_mode == MODE_NONE |=> res_valid && sample_out == $past(s1_x))
    else $error("pass-through sample altered");

endmodule
